>>> hdl/sjf_pkg.sv
// ----------------------------------------------------------------------------
// sjf_pkg
// Shared constants and controller/datapath interface types for the
// shortest-job-first scheduler.
// ----------------------------------------------------------------------------
package sjf_pkg;

  localparam int MAX_PROCS = 32;
  localparam int IDX_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);

  localparam int TIME_W    = 16;
  localparam int PIDX_W    = 6;
  localparam int CLK_W     = 23;
  localparam int SUM_W     = 29;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 136;

  typedef struct packed {
    logic load;
    logic scan_init;
    logic scan;
    logic emit;
    logic clear;
  } sjf_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic last_pick;
    logic out_free;
  } sjf_status_t;

endpackage

>>> hdl/sjf_ctrl.sv
// ----------------------------------------------------------------------------
// sjf_ctrl
// Controller: load items, run one scan per pick, then emit the pick.
// ----------------------------------------------------------------------------
module sjf_ctrl
  import sjf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tlast,
  output logic        in_tready,
  input  sjf_status_t status,
  output sjf_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_LOAD,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_tready = (state_r == S_LOAD);

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    unique case (state_r)
      S_LOAD: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (in_tlast) begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.last_pick) begin
            cmd.clear = 1'b1;
            state_nxt = S_LOAD;
          end else begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_SCAN;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hdl/sjf_dpath.sv
// ----------------------------------------------------------------------------
// sjf_dpath
// Datapath: process store, done flags, scan trackers, timing arithmetic and
// the output register.
// ----------------------------------------------------------------------------
module sjf_dpath
  import sjf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  sjf_cmd_t              cmd,
  output sjf_status_t           status,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser,
  output logic                  out_tlast
);

  logic [TIME_W-1:0] arr_mem [MAX_PROCS];
  logic [TIME_W-1:0] bur_mem [MAX_PROCS];
  logic [MAX_PROCS-1:0] done_r;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] picks_r;
  logic [CNT_W-1:0] ptr_r;
  logic             ovf_r;
  logic [CLK_W-1:0] cur_r;
  logic [SUM_W-1:0] tsum_r;
  logic [SUM_W-1:0] wsum_r;

  // read pipeline
  logic              rv_r;
  logic              rdone_r;
  logic [IDX_W-1:0]  ridx_r;
  logic [TIME_W-1:0] rarr_r;
  logic [TIME_W-1:0] rbur_r;

  // best among arrived: shortest burst, then earliest arrival
  logic              ha_r;
  logic [IDX_W-1:0]  ba_idx_r;
  logic [TIME_W-1:0] ba_arr_r;
  logic [TIME_W-1:0] ba_bur_r;
  // best among earliest arrivals: earliest arrival, then shortest burst
  logic              he_r;
  logic [IDX_W-1:0]  be_idx_r;
  logic [TIME_W-1:0] be_arr_r;
  logic [TIME_W-1:0] be_bur_r;

  logic              out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic              out_user_r;
  logic              out_last_r;

  logic              arrived;
  logic              upd_a;
  logic              upd_e;
  logic [IDX_W-1:0]  sel_idx;
  logic [TIME_W-1:0] sel_arr;
  logic [TIME_W-1:0] sel_bur;
  logic [CLK_W-1:0]  base;
  logic [CLK_W-1:0]  cnew;
  logic [CLK_W-1:0]  tat;
  logic [CLK_W-1:0]  wt;
  logic [SUM_W-1:0]  tsum_nxt;
  logic [SUM_W-1:0]  wsum_nxt;
  logic              last_pick;

  assign arrived = ({{(CLK_W-TIME_W){1'b0}}, rarr_r} <= cur_r);
  assign upd_a = rv_r && !rdone_r && arrived &&
                 (!ha_r || (rbur_r < ba_bur_r) ||
                  ((rbur_r == ba_bur_r) && (rarr_r < ba_arr_r)));
  assign upd_e = rv_r && !rdone_r &&
                 (!he_r || (rarr_r < be_arr_r) ||
                  ((rarr_r == be_arr_r) && (rbur_r < be_bur_r)));

  assign sel_idx = ha_r ? ba_idx_r : be_idx_r;
  assign sel_arr = ha_r ? ba_arr_r : be_arr_r;
  assign sel_bur = ha_r ? ba_bur_r : be_bur_r;
  assign base    = ha_r ? cur_r : {{(CLK_W-TIME_W){1'b0}}, be_arr_r};
  assign cnew    = base + {{(CLK_W-TIME_W){1'b0}}, sel_bur};
  assign tat     = cnew - {{(CLK_W-TIME_W){1'b0}}, sel_arr};
  assign wt      = base - {{(CLK_W-TIME_W){1'b0}}, sel_arr};
  assign tsum_nxt = tsum_r + {{(SUM_W-CLK_W){1'b0}}, tat};
  assign wsum_nxt = wsum_r + {{(SUM_W-CLK_W){1'b0}}, wt};
  assign last_pick = ((picks_r + 1'b1) == count_r);

  assign status.scan_done = (ptr_r == count_r) && !rv_r;
  assign status.last_pick = last_pick;
  assign status.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  // store write and scan read
  always_ff @(posedge clk) begin
    if (cmd.load && (count_r < CNT_W'(MAX_PROCS))) begin
      arr_mem[count_r[IDX_W-1:0]] <= in_tdata[TIME_W-1:0];
      bur_mem[count_r[IDX_W-1:0]] <= in_tdata[2*TIME_W-1:TIME_W];
    end
    rarr_r  <= arr_mem[ptr_r[IDX_W-1:0]];
    rbur_r  <= bur_mem[ptr_r[IDX_W-1:0]];
    rdone_r <= done_r[ptr_r[IDX_W-1:0]];
    ridx_r  <= ptr_r[IDX_W-1:0];
  end

  // control and set state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r  <= '0;
      count_r <= '0;
      picks_r <= '0;
      ptr_r   <= '0;
      ovf_r   <= 1'b0;
      cur_r   <= '0;
      tsum_r  <= '0;
      wsum_r  <= '0;
      rv_r    <= 1'b0;
      ha_r    <= 1'b0;
      he_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (count_r < CNT_W'(MAX_PROCS)) begin
          count_r <= count_r + 1'b1;
        end else begin
          ovf_r <= 1'b1;
        end
      end

      if (cmd.scan_init) begin
        ptr_r <= '0;
        rv_r  <= 1'b0;
        ha_r  <= 1'b0;
        he_r  <= 1'b0;
      end else if (cmd.scan) begin
        if (ptr_r != count_r) begin
          ptr_r <= ptr_r + 1'b1;
          rv_r  <= 1'b1;
        end else begin
          rv_r  <= 1'b0;
        end
        if (upd_a) begin
          ha_r <= 1'b1;
        end
        if (upd_e) begin
          he_r <= 1'b1;
        end
      end

      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (cmd.clear) begin
        done_r  <= '0;
        count_r <= '0;
        picks_r <= '0;
        ovf_r   <= 1'b0;
        cur_r   <= '0;
        tsum_r  <= '0;
        wsum_r  <= '0;
      end else if (cmd.emit) begin
        done_r[sel_idx]  <= 1'b1;
        cur_r            <= cnew;
        tsum_r           <= tsum_nxt;
        wsum_r           <= wsum_nxt;
        picks_r          <= picks_r + 1'b1;
      end
    end
  end

  // tracker payload
  always_ff @(posedge clk) begin
    if (cmd.scan && upd_a) begin
      ba_idx_r <= ridx_r;
      ba_arr_r <= rarr_r;
      ba_bur_r <= rbur_r;
    end
    if (cmd.scan && upd_e) begin
      be_idx_r <= ridx_r;
      be_arr_r <= rarr_r;
      be_bur_r <= rbur_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= {3'b000,
                     last_pick ? wsum_nxt : {SUM_W{1'b0}},
                     last_pick ? tsum_nxt : {SUM_W{1'b0}},
                     wt,
                     tat,
                     cnew,
                     {{(PIDX_W-IDX_W){1'b0}}, sel_idx}};
      out_user_r <= ovf_r;
      out_last_r <= last_pick;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_PROCS))
    else $error("fill count beyond capacity");

  a_emit_has_pick: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (ha_r || he_r))
    else $error("emit without a candidate");

  a_emit_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !done_r[sel_idx])
    else $error("picked a finished process");

  a_emit_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (out_valid_r && (out_last_r == $past(last_pick))))
    else $error("result register not loaded on emit");
`endif

endmodule

>>> hdl/sjf_nonpreemptive_scheduler.sv
// Input: items load at one per cycle while in_tready is high (load state only); each
//   result follows a scan of the N stored processes, one entry per cycle through the
//   single read port of the process store, and waits for a free output register.
// Output: N results per set; no new item is taken until the set's last result is emitted.
// Reset: synchronous active-low rst_n clears the fill count, done flags, clock
//   and sums; the process store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// sjf_nonpreemptive_scheduler
// Non-preemptive shortest-job-first scheduler over a set of buffered
// processes, emitting one timing result per pick in schedule order.
// ----------------------------------------------------------------------------
module sjf_nonpreemptive_scheduler
  import sjf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // arrival_time, burst_time
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // process_index, completion_time, turnaround_time, waiting_time,
  // sum_turnaround, sum_waiting, zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser,  // dropped_any
  output logic                  out_tlast
);

  sjf_cmd_t    cmd;
  sjf_status_t status;

  sjf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  sjf_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

>>> sim/sjf_nonpreemptive_scheduler_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sjf_nonpreemptive_scheduler_test
// Self-checking bench for the shortest-job-first scheduler. Process sets
// are streamed in, a local scheduler works out every pick of each set, and
// each result transfer is checked field by field against the oldest pick
// still pending. Covers extreme times, ties, idle clock jumps, zero bursts,
// a full store and dropped items, under three idling patterns.
// ----------------------------------------------------------------------------
module sjf_nonpreemptive_scheduler_test;
  import sjf_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    logic [PIDX_W-1:0] pidx;
    logic [CLK_W-1:0]  done_at;
    logic [CLK_W-1:0]  tat;
    logic [CLK_W-1:0]  wt;
    logic [SUM_W-1:0]  sum_tat;
    logic [SUM_W-1:0]  sum_wt;
    logic              dropped;
    logic              last;
  } pick_rec_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // arrival_time, burst_time
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // process_index, completion_time, turnaround_time, waiting_time,
  // sum_turnaround, sum_waiting, zero fill
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;  // dropped_any
  logic                  out_tlast;

  logic [TIME_W-1:0] arr_mem [MAX_PROCS];
  logic [TIME_W-1:0] bur_mem [MAX_PROCS];
  bit                finished [MAX_PROCS];
  int unsigned       fill_cnt = 0;
  bit                store_ovf = 1'b0;
  pick_rec_t         pending_picks [$];

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int fail_cnt      = 0;
  int quiet_cycles  = 0;

  sjf_nonpreemptive_scheduler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic void plan_schedule();
    int unsigned       n;
    int unsigned       pick;
    bit                have;
    bit                any;
    logic [CLK_W-1:0]  clk_now;
    logic [CLK_W-1:0]  earliest;
    logic [SUM_W-1:0]  s_tat;
    logic [SUM_W-1:0]  s_wt;
    pick_rec_t         r;
    n = fill_cnt;
    clk_now = '0;
    s_tat = '0;
    s_wt = '0;
    for (int k = 0; k < n; k++) begin
      any = 1'b0;
      earliest = '0;
      for (int j = 0; j < n; j++) begin
        if (!finished[j]) begin
          if (!any || CLK_W'(arr_mem[j]) < earliest) earliest = CLK_W'(arr_mem[j]);
          any = 1'b1;
        end
      end
      // jump forward when nothing unfinished has arrived
      if (clk_now < earliest) clk_now = earliest;
      have = 1'b0;
      pick = 0;
      for (int j = 0; j < n; j++) begin
        if (!finished[j] && CLK_W'(arr_mem[j]) <= clk_now) begin
          if (!have || bur_mem[j] < bur_mem[pick] ||
              (bur_mem[j] == bur_mem[pick] && arr_mem[j] < arr_mem[pick])) begin
            pick = j;
            have = 1'b1;
          end
        end
      end
      clk_now    = clk_now + CLK_W'(bur_mem[pick]);
      r.pidx     = pick[PIDX_W-1:0];
      r.done_at  = clk_now;
      r.tat      = clk_now - CLK_W'(arr_mem[pick]);
      r.wt       = r.tat - CLK_W'(bur_mem[pick]);
      finished[pick] = 1'b1;
      s_tat      = s_tat + SUM_W'(r.tat);
      s_wt       = s_wt + SUM_W'(r.wt);
      r.dropped  = store_ovf;
      r.last     = (k + 1 == n);
      r.sum_tat  = r.last ? s_tat : '0;
      r.sum_wt   = r.last ? s_wt : '0;
      pending_picks.push_back(r);
    end
    for (int j = 0; j < MAX_PROCS; j++) finished[j] = 1'b0;
    fill_cnt = 0;
    store_ovf = 1'b0;
  endfunction

  function automatic void admit_process(logic [TIME_W-1:0] arr, logic [TIME_W-1:0] bur,
                                        logic last);
    if (fill_cnt < MAX_PROCS) begin
      arr_mem[fill_cnt]  = arr;
      bur_mem[fill_cnt]  = bur;
      finished[fill_cnt] = 1'b0;
      fill_cnt++;
    end else begin
      store_ovf = 1'b1;
    end
    if (last) plan_schedule();
  endfunction

  task automatic send_process(logic [TIME_W-1:0] arr, logic [TIME_W-1:0] bur, logic last);
    while ($urandom_range(99) < src_idle_pct) @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = {bur, arr};
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    admit_process(arr, bur, last);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic note_fail(string what, longint unsigned want, longint unsigned got);
    fail_cnt++;
    if (fail_cnt <= 10)
      $display("%0t mismatch %s: expected %0d actual %0d", $time, what, want, got);
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin : check_results
    pick_rec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_picks.size() == 0) begin
        note_fail("unexpected result, index", 0, out_tdata[5:0]);
      end else begin
        want = pending_picks.pop_front();
        if (out_tdata[5:0] !== want.pidx)
          note_fail("process_index", want.pidx, out_tdata[5:0]);
        if (out_tdata[28:6] !== want.done_at)
          note_fail("completion_time", want.done_at, out_tdata[28:6]);
        if (out_tdata[51:29] !== want.tat)
          note_fail("turnaround_time", want.tat, out_tdata[51:29]);
        if (out_tdata[74:52] !== want.wt)
          note_fail("waiting_time", want.wt, out_tdata[74:52]);
        if (out_tdata[103:75] !== want.sum_tat)
          note_fail("sum_turnaround", want.sum_tat, out_tdata[103:75]);
        if (out_tdata[132:104] !== want.sum_wt)
          note_fail("sum_waiting", want.sum_wt, out_tdata[132:104]);
        if (out_tuser !== want.dropped)
          note_fail("dropped_any", want.dropped, out_tuser);
        if (out_tlast !== want.last)
          note_fail("last_result", want.last, out_tlast);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_directed();
    // zero burst at tick zero, then both fields at their maximum
    send_process(16'd0, 16'd0, 1'b1);
    send_process(16'hFFFF, 16'hFFFF, 1'b1);
    // idle clock: gaps before every arrival
    send_process(16'd100, 16'd5, 1'b0);
    send_process(16'd10, 16'd3, 1'b0);
    send_process(16'd500, 16'd2, 1'b1);
    // equal bursts: break on arrival, then on input order
    send_process(16'd0, 16'd4, 1'b0);
    send_process(16'd0, 16'd4, 1'b0);
    send_process(16'd2, 16'd4, 1'b0);
    send_process(16'd0, 16'd1, 1'b0);
    send_process(16'd5, 16'd0, 1'b0);
    send_process(16'd1, 16'd4, 1'b1);
    // extremes mixed within one set
    send_process(16'hFFFF, 16'd0, 1'b0);
    send_process(16'd0, 16'hFFFF, 1'b0);
    send_process(16'h8000, 16'd1, 1'b0);
    send_process(16'd1, 16'h8000, 1'b0);
    send_process(16'h5555, 16'hAAAA, 1'b0);
    send_process(16'hAAAA, 16'h5555, 1'b1);
  endtask

  task automatic test_random_sets(int n_items);
    int sent;
    int set_len;
    int mode;
    logic [TIME_W-1:0] arr;
    logic [TIME_W-1:0] bur;
    sent = 0;
    while (sent < n_items) begin
      set_len = ($urandom_range(9) == 0) ? $urandom_range(10, 16) : $urandom_range(1, 6);
      mode = $urandom_range(2);
      for (int i = 0; i < set_len; i++) begin
        case (mode)
          0: begin
            arr = TIME_W'($urandom_range(40));
            bur = TIME_W'($urandom_range(12));
          end
          1: begin
            arr = TIME_W'($urandom);
            bur = TIME_W'($urandom);
          end
          default: begin
            arr = TIME_W'($urandom_range(3000));
            bur = TIME_W'($urandom_range(200));
          end
        endcase
        send_process(arr, bur, i == set_len - 1);
      end
      sent += set_len;
    end
  endtask

  task automatic test_full_store();
    int extra;
    // exactly full: nothing dropped
    for (int i = 0; i < MAX_PROCS; i++)
      send_process(TIME_W'($urandom_range(300)), TIME_W'($urandom_range(50)),
                   i == MAX_PROCS - 1);
    // overfill: the closing item itself is dropped yet starts the schedule
    extra = $urandom_range(1, 3);
    for (int i = 0; i < MAX_PROCS + extra; i++)
      send_process(TIME_W'($urandom), TIME_W'($urandom_range(1000)),
                   i == MAX_PROCS + extra - 1);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    src_idle_pct  = 24;
    sink_idle_pct = 67;
    test_directed();
    test_random_sets(15);

    src_idle_pct  = 67;
    sink_idle_pct = 24;
    test_random_sets(15);
    test_full_store();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_sets(15);

    while (pending_picks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
